// ===== sv/tqa_pkg.sv =====
package tqa_pkg;

	localparam int TQA_DATA_WIDTH = 32;
	localparam logic [31:0] SCALE_RESET = 32'd281475;

	localparam logic [2:0] REG_E_X = 3'd0;
	localparam logic [2:0] REG_E_Y = 3'd1;
	localparam logic [2:0] REG_E_Z = 3'd2;
	localparam logic [2:0] REG_B_X = 3'd3;
	localparam logic [2:0] REG_B_Y = 3'd4;
	localparam logic [2:0] REG_B_Z = 3'd5;
	localparam logic [2:0] REG_SCALE = 3'd6;

	localparam logic [4:0] SRC_IA0 = 5'd0;
	localparam logic [4:0] SRC_IB0 = 5'd3;
	localparam logic [4:0] SRC_CM0 = 5'd6;
	localparam logic [4:0] SRC_CV0 = 5'd9;
	localparam logic [4:0] SRC_DS0 = 5'd12;
	localparam logic [4:0] SRC_CP0 = 5'd15;
	localparam logic [4:0] SRC_E0 = 5'd18;
	localparam logic [4:0] SRC_B0 = 5'd21;
	localparam logic [4:0] SRC_LF0 = 5'd24;
	localparam logic [4:0] SRC_IQ = 5'd27;
	localparam logic [4:0] SRC_HQ = 5'd28;
	localparam logic [4:0] SRC_X = 5'd29;
	localparam logic [4:0] SRC_SC = 5'd30;

	localparam logic [3:0] ACT_HOLD = 4'd0;
	localparam logic [3:0] ACT_FT = 4'd1;
	localparam logic [3:0] ACT_CM = 4'd2;
	localparam logic [3:0] ACT_CV = 4'd3;
	localparam logic [3:0] ACT_LF = 4'd4;
	localparam logic [3:0] ACT_X = 4'd5;
	localparam logic [3:0] ACT_RE = 4'd6;
	localparam logic [3:0] ACT_RM = 4'd7;
	localparam logic [3:0] ACT_RL = 4'd8;

	localparam logic [5:0] PC_BEAT0 = 6'd0;
	localparam logic [5:0] PC_B0_END = 6'd8;
	localparam logic [5:0] PC_BEAT1 = 6'd9;
	localparam logic [5:0] PC_B1_END = 6'd11;
	localparam logic [5:0] PC_TERMS = 6'd18;
	localparam logic [5:0] PC_END = 6'd41;

	localparam logic signed [63:0] SAT_MAX = 64'sh7fff_ffff_ffff_ffff;
	localparam logic signed [63:0] SAT_MIN = 64'sh8000_0000_0000_0000;

	typedef struct packed {
		logic              func;
		logic signed [31:0] vec_a_x;
		logic signed [31:0] vec_a_y;
		logic signed [31:0] vec_a_z;
		logic signed [31:0] vec_b_x;
		logic signed [31:0] vec_b_y;
		logic signed [31:0] vec_b_z;
		logic signed [31:0] charge;
		logic              last_atom;
	} in_t;

	typedef struct packed {
		logic signed [63:0] torque_x;
		logic signed [63:0] torque_y;
		logic signed [63:0] torque_z;
	} out_t;

	typedef struct packed {
		logic [4:0] sel_a;
		logic [4:0] sel_b;
		logic [3:0] act;
		logic [1:0] idx;
	} step_t;

	typedef struct packed {
		logic  load;
		logic  start;
		logic  wb;
		logic  finish;
		step_t step;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
	} stat_t;

	function automatic logic signed [63:0] sat113(input logic signed [112:0] v);
		if (v[112:63] == {50{v[63]}})
			return v[63:0];
		return v[112] ? SAT_MIN : SAT_MAX;
	endfunction

	function automatic logic signed [63:0] sat80(input logic signed [79:0] v);
		if (v[79:63] == {17{v[63]}})
			return v[63:0];
		return v[79] ? SAT_MIN : SAT_MAX;
	endfunction

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? SAT_MIN : SAT_MAX;
		return s[63:0];
	endfunction

	function automatic logic [4:0] src(input logic [4:0] base, input logic [1:0] i);
		return base + {3'd0, i};
	endfunction

	// operation sequence: position beat, velocity beat, then end of molecule
	function automatic step_t prog_step(input logic [5:0] pc);
		step_t s;
		logic [4:0] off;
		logic [1:0] i, j, k;
		off = 5'(pc - PC_TERMS);
		i = off[4:3];
		unique case (i)
			2'd0: begin j = 2'd1; k = 2'd2; end
			2'd1: begin j = 2'd2; k = 2'd0; end
			default: begin j = 2'd0; k = 2'd1; end
		endcase
		s = '{SRC_X, SRC_SC, ACT_HOLD, 2'd0};
		if (pc < PC_TERMS) begin
			unique case (pc)
				6'd0: s = '{src(SRC_IA0, 2'd1), src(SRC_IB0, 2'd2), ACT_HOLD, 2'd0};
				6'd1: s = '{src(SRC_IA0, 2'd2), src(SRC_IB0, 2'd1), ACT_FT, 2'd0};
				6'd2: s = '{src(SRC_IA0, 2'd2), src(SRC_IB0, 2'd0), ACT_HOLD, 2'd0};
				6'd3: s = '{src(SRC_IA0, 2'd0), src(SRC_IB0, 2'd2), ACT_FT, 2'd1};
				6'd4: s = '{src(SRC_IA0, 2'd0), src(SRC_IB0, 2'd1), ACT_HOLD, 2'd0};
				6'd5: s = '{src(SRC_IA0, 2'd1), src(SRC_IB0, 2'd0), ACT_FT, 2'd2};
				6'd6: s = '{SRC_IQ, src(SRC_IA0, 2'd0), ACT_CM, 2'd0};
				6'd7: s = '{SRC_IQ, src(SRC_IA0, 2'd1), ACT_CM, 2'd1};
				6'd8: s = '{SRC_IQ, src(SRC_IA0, 2'd2), ACT_CM, 2'd2};
				6'd9: s = '{SRC_HQ, src(SRC_IA0, 2'd0), ACT_CV, 2'd0};
				6'd10: s = '{SRC_HQ, src(SRC_IA0, 2'd1), ACT_CV, 2'd1};
				6'd11: s = '{SRC_HQ, src(SRC_IA0, 2'd2), ACT_CV, 2'd2};
				6'd12: s = '{src(SRC_CV0, 2'd1), src(SRC_B0, 2'd2), ACT_HOLD, 2'd0};
				6'd13: s = '{src(SRC_CV0, 2'd2), src(SRC_B0, 2'd1), ACT_LF, 2'd0};
				6'd14: s = '{src(SRC_CV0, 2'd2), src(SRC_B0, 2'd0), ACT_HOLD, 2'd0};
				6'd15: s = '{src(SRC_CV0, 2'd0), src(SRC_B0, 2'd2), ACT_LF, 2'd1};
				6'd16: s = '{src(SRC_CV0, 2'd0), src(SRC_B0, 2'd1), ACT_HOLD, 2'd0};
				default: s = '{src(SRC_CV0, 2'd1), src(SRC_B0, 2'd0), ACT_LF, 2'd2};
			endcase
		end else begin
			unique case (off[2:0])
				3'd0: s = '{src(SRC_CM0, j), src(SRC_E0, k), ACT_HOLD, i};
				3'd1: s = '{src(SRC_CM0, k), src(SRC_E0, j), ACT_X, i};
				3'd2: s = '{SRC_X, SRC_SC, ACT_RE, i};
				3'd3: s = '{src(SRC_DS0, j), src(SRC_B0, k), ACT_HOLD, i};
				3'd4: s = '{src(SRC_DS0, k), src(SRC_B0, j), ACT_RM, i};
				3'd5: s = '{src(SRC_CP0, j), src(SRC_LF0, k), ACT_HOLD, i};
				3'd6: s = '{src(SRC_CP0, k), src(SRC_LF0, j), ACT_X, i};
				default: s = '{SRC_X, SRC_SC, ACT_RL, i};
			endcase
		end
		return s;
	endfunction

endpackage

// ===== sv/tqa_mul.sv =====
module tqa_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [63:0]  a,
	input  logic signed [63:0]  b,
	output logic                done,
	output logic signed [127:0] p
);
	logic signed [63:0] a_q, b_q;
	logic signed [127:0] acc_q;
	logic [1:0] k_q;
	logic busy_q, done_q;
	logic signed [16:0] ch;
	logic signed [80:0] pp;
	logic signed [127:0] pe;

	always_comb begin
		ch = {(k_q == 2'd3) ? b_q[63] : 1'b0, b_q[{k_q, 4'b0} +: 16]};
		pp = a_q * ch;
		pe = 128'(pp);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				k_q <= 2'd0;
			end else if (busy_q) begin
				k_q <= k_q + 2'd1;
				if (k_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + (pe <<< {k_q, 4'b0});
		end
	end

	assign done = done_q;
	assign p = acc_q;
endmodule

// ===== sv/tqa_ctrl.sv =====
module tqa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           func,
	input  logic           last_atom,
	input  logic           out_stall,
	input  tqa_pkg::stat_t stat,
	output tqa_pkg::cmd_t  cmd,
	output logic           in_stall,
	output logic           out_valid
);
	import tqa_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	logic [1:0] state_q;
	logic [5:0] pc_q;
	logic last_q, out_valid_q;
	logic accept, finish;

	assign accept = (state_q == ST_IDLE) && in_valid;
	assign finish = (state_q == ST_FLUSH) && (!out_valid_q || !out_stall);

	always_comb begin
		cmd.load = accept;
		cmd.start = (state_q == ST_ISSUE);
		cmd.wb = (state_q == ST_WAIT) && stat.mul_done;
		cmd.finish = finish;
		cmd.step = prog_step(pc_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= PC_BEAT0;
			last_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (finish)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						pc_q <= func ? PC_BEAT1 : PC_BEAT0;
						last_q <= func & last_atom;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (stat.mul_done) begin
						if (pc_q == PC_B0_END || (pc_q == PC_B1_END && !last_q))
							state_q <= ST_IDLE;
						else if (pc_q == PC_END)
							state_q <= ST_FLUSH;
						else begin
							pc_q <= pc_q + 6'd1;
							state_q <= ST_ISSUE;
						end
					end
				end
				default: begin
					if (finish)
						state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
endmodule

// ===== sv/tqa_dp.sv =====
module tqa_dp #(
	parameter int DATA_WIDTH = tqa_pkg::TQA_DATA_WIDTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  tqa_pkg::cmd_t  cmd,
	input  tqa_pkg::in_t   in_data,
	input  logic           cfg_we,
	input  logic [2:0]     cfg_index,
	input  logic [31:0]    cfg_data,
	output tqa_pkg::stat_t stat,
	output tqa_pkg::out_t  out_data
);
	import tqa_pkg::*;

	function automatic logic signed [63:0] sx(input logic [31:0] v);
		return 64'(signed'(v[DATA_WIDTH-1:0]));
	endfunction

	logic [31:0] e_q [3];
	logic [31:0] b_q [3];
	logic [31:0] scale_q;
	logic signed [63:0] ia_q [3];
	logic signed [63:0] ib_q [3];
	logic signed [63:0] iq_q, hq_q, x_q;
	logic signed [63:0] ft_q [3];
	logic signed [63:0] cm_q [3];
	logic signed [63:0] cv_q [3];
	logic signed [63:0] cp_q [3];
	logic signed [63:0] ds_q [3];
	logic signed [63:0] lf_q [3];
	logic signed [63:0] r_q [3];
	logic signed [111:0] t_q;
	out_t out_q;

	logic signed [63:0] opa, opb;
	logic signed [127:0] prod;
	logic mul_done;
	logic signed [111:0] sh16;
	logic signed [79:0] sh48;
	logic signed [112:0] diff;
	logic signed [63:0] q_in;
	logic signed [63:0] a_in [3];
	logic signed [63:0] b_in [3];

	function automatic logic signed [63:0] operand(input logic [4:0] code);
		logic signed [63:0] v;
		v = '0;
		unique case (code)
			SRC_IA0: v = ia_q[0];
			SRC_IA0 + 5'd1: v = ia_q[1];
			SRC_IA0 + 5'd2: v = ia_q[2];
			SRC_IB0: v = ib_q[0];
			SRC_IB0 + 5'd1: v = ib_q[1];
			SRC_IB0 + 5'd2: v = ib_q[2];
			SRC_CM0: v = cm_q[0];
			SRC_CM0 + 5'd1: v = cm_q[1];
			SRC_CM0 + 5'd2: v = cm_q[2];
			SRC_CV0: v = cv_q[0];
			SRC_CV0 + 5'd1: v = cv_q[1];
			SRC_CV0 + 5'd2: v = cv_q[2];
			SRC_DS0: v = ds_q[0];
			SRC_DS0 + 5'd1: v = ds_q[1];
			SRC_DS0 + 5'd2: v = ds_q[2];
			SRC_CP0: v = cp_q[0];
			SRC_CP0 + 5'd1: v = cp_q[1];
			SRC_CP0 + 5'd2: v = cp_q[2];
			SRC_E0: v = sx(e_q[0]);
			SRC_E0 + 5'd1: v = sx(e_q[1]);
			SRC_E0 + 5'd2: v = sx(e_q[2]);
			SRC_B0: v = sx(b_q[0]);
			SRC_B0 + 5'd1: v = sx(b_q[1]);
			SRC_B0 + 5'd2: v = sx(b_q[2]);
			SRC_LF0: v = lf_q[0];
			SRC_LF0 + 5'd1: v = lf_q[1];
			SRC_LF0 + 5'd2: v = lf_q[2];
			SRC_IQ: v = iq_q;
			SRC_HQ: v = hq_q;
			SRC_X: v = x_q;
			SRC_SC: v = {32'd0, scale_q};
			default: v = '0;
		endcase
		return v;
	endfunction

	always_comb begin
		opa = operand(cmd.step.sel_a);
		opb = operand(cmd.step.sel_b);
		sh16 = prod[127:16];
		sh48 = prod[127:48];
		diff = 113'(t_q) - 113'(sh16);
		q_in = sx(in_data.charge);
		a_in[0] = sx(in_data.vec_a_x);
		a_in[1] = sx(in_data.vec_a_y);
		a_in[2] = sx(in_data.vec_a_z);
		b_in[0] = sx(in_data.vec_b_x);
		b_in[1] = sx(in_data.vec_b_y);
		b_in[2] = sx(in_data.vec_b_z);
	end

	tqa_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(cmd.start),
		.a(opa), .b(opb), .done(mul_done), .p(prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < 3; n++) begin
				e_q[n] <= '0;
				b_q[n] <= '0;
			end
			scale_q <= SCALE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_E_X: e_q[0] <= cfg_data;
				REG_E_Y: e_q[1] <= cfg_data;
				REG_E_Z: e_q[2] <= cfg_data;
				REG_B_X: b_q[0] <= cfg_data;
				REG_B_Y: b_q[1] <= cfg_data;
				REG_B_Z: b_q[2] <= cfg_data;
				REG_SCALE: scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < 3; n++) begin
				ft_q[n] <= '0;
				cm_q[n] <= '0;
				cv_q[n] <= '0;
				cp_q[n] <= '0;
				ds_q[n] <= '0;
			end
			hq_q <= '0;
		end else if (cmd.finish) begin
			for (int n = 0; n < 3; n++) begin
				ft_q[n] <= '0;
				cm_q[n] <= '0;
				cv_q[n] <= '0;
				cp_q[n] <= '0;
				ds_q[n] <= '0;
			end
			hq_q <= '0;
		end else if (cmd.load) begin
			if (!in_data.func) begin
				for (int n = 0; n < 3; n++)
					if (q_in != 64'sd0)
						cp_q[n] <= sat_add(cp_q[n], a_in[n]);
				hq_q <= q_in;
			end else begin
				for (int n = 0; n < 3; n++)
					ds_q[n] <= sat_add(ds_q[n], b_in[n]);
			end
		end else if (cmd.wb) begin
			unique case (cmd.step.act)
				ACT_FT: ft_q[cmd.step.idx] <= sat_add(ft_q[cmd.step.idx], sat113(diff));
				ACT_CM: cm_q[cmd.step.idx] <= sat_add(cm_q[cmd.step.idx], sat113(113'(sh16)));
				ACT_CV: cv_q[cmd.step.idx] <= sat_add(cv_q[cmd.step.idx], sat113(113'(sh16)));
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int n = 0; n < 3; n++) begin
				ia_q[n] <= a_in[n];
				ib_q[n] <= b_in[n];
			end
			iq_q <= q_in;
		end
		if (cmd.wb) begin
			unique case (cmd.step.act)
				ACT_HOLD: t_q <= sh16;
				ACT_LF: lf_q[cmd.step.idx] <= sat113(diff);
				ACT_X: x_q <= sat113(diff);
				ACT_RE: r_q[cmd.step.idx] <= sat_add(ft_q[cmd.step.idx], sat80(sh48));
				ACT_RM: r_q[cmd.step.idx] <= sat_add(r_q[cmd.step.idx], sat113(diff));
				ACT_RL: r_q[cmd.step.idx] <= sat_add(r_q[cmd.step.idx], sat80(sh48));
				default: ;
			endcase
		end
		if (cmd.finish) begin
			out_q.torque_x <= r_q[0];
			out_q.torque_y <= r_q[1];
			out_q.torque_z <= r_q[2];
		end
	end

	assign stat.mul_done = mul_done;
	assign out_data = out_q;
endmodule

// ===== sv/molecule_torque_accumulator.sv =====
// a position beat and a velocity beat each run to completion before the next
// request is accepted; on the last atom the torque result is produced after the
// velocity beat, before the next input request is accepted
// one request at a time; every product runs on the shared iterative
// multiplier with 16-bit digits
// arst_n clears control, accumulators and field registers; scale resets to 1e-9
module molecule_torque_accumulator #(
	parameter int DATA_WIDTH = tqa_pkg::TQA_DATA_WIDTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  tqa_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output tqa_pkg::out_t out_data,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [31:0]   cfg_data
);
	import tqa_pkg::*;

	cmd_t cmd;
	stat_t stat;

	tqa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .func(in_data.func),
		.last_atom(in_data.last_atom), .out_stall(out_stall), .stat(stat),
		.cmd(cmd), .in_stall(in_stall), .out_valid(out_valid)
	);

	tqa_dp #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_data(in_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.stat(stat), .out_data(out_data)
	);
endmodule

// ===== sv/tqa_checker.sv =====
module tqa_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_stall,
	input logic          out_valid,
	input logic          out_stall,
	input tqa_pkg::out_t out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while busy");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without work");

	a_idle_at_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("not idle after result");
endmodule

bind molecule_torque_accumulator tqa_checker u_tqa_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
